FILE: src/msvf_pkg.sv
// Shared types, constants and helper functions of the morphing state-variable filter.
`default_nettype none
package msvf_pkg;

  // Field and datapath widths.
  localparam int SAMPLE_W = 24;
  localparam int STATE_W  = 32;
  localparam int COEF_W   = 18;
  localparam int MORPH_W  = 17;
  localparam int GAIN_W   = 16;
  localparam int V0_W     = 28;
  localparam int V_W      = 40;
  localparam int Y_W      = 42;
  localparam int SAT_W    = V_W + 2;
  localparam int MA_W     = 40;
  localparam int MB_W     = 27;
  localparam int PROD_W   = 56;
  localparam int FRAC_W   = 26;
  localparam int TANH_W   = 24;
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;

  // Default sizes.
  localparam int NUM_CHANNELS_DEF = 2;
  localparam int TANH_DEPTH_DEF   = 256;

  // Register reset values.
  localparam logic [COEF_W-1:0]  A1_RST    = 18'd65536;
  localparam logic [COEF_W-1:0]  A2_RST    = 18'd32768;
  localparam logic [COEF_W-1:0]  A3_RST    = 18'd16384;
  localparam logic [COEF_W-1:0]  K_RST     = 18'd131072;
  localparam logic [MORPH_W-1:0] MORPH_RST = 17'd0;
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 16'd4096;
  localparam logic               PRE_RST   = 1'b1;

  // Morph limits and output full scale.
  localparam logic [MORPH_W-1:0] MORPH_ONE  = 17'd65536;
  localparam logic [MORPH_W-1:0] MORPH_HALF = 17'd32768;
  localparam logic [24:0]        OUT_MAX    = 25'd8388607;

  // Register indexes.
  typedef enum logic [2:0] {
    REG_A1    = 3'd0,
    REG_A2    = 3'd1,
    REG_A3    = 3'd2,
    REG_K     = 3'd3,
    REG_MORPH = 3'd4,
    REG_GAIN  = 3'd5,
    REG_PRE   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [COEF_W-1:0]  a1;
    logic [COEF_W-1:0]  a2;
    logic [COEF_W-1:0]  a3;
    logic [COEF_W-1:0]  k;
    logic [MORPH_W-1:0] morph;
    logic [GAIN_W-1:0]  gain;
    logic               pre;
  } cfg_t;

  // Sequencer steps; each is also the datapath operation of that cycle.
  typedef enum logic [4:0] {
    ST_IDLE, ST_DRV, ST_V0, ST_V3, ST_A2V3, ST_V1, ST_ACC2, ST_V2, ST_HP,
    ST_BL2, ST_Y, ST_YDRV, ST_POST, ST_MAG, ST_IDX, ST_RDLO, ST_RDHI,
    ST_INTP, ST_RES
  } state_t;

  typedef struct packed {
    state_t op;
    logic   load;
    logic   out_load;
  } cmd_t;

  // Round half up, then arithmetic shift right by s.
  function automatic logic signed [PROD_W-1:0] rnd_sh(input logic signed [PROD_W-1:0] v,
                                                      input int unsigned s);
    logic signed [PROD_W-1:0] t;
    t = v + $signed(PROD_W'(1) << (s - 1));
    return t >>> s;
  endfunction

  // Saturate to signed 32 bit.
  function automatic logic signed [STATE_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = $signed(SAT_W'(32'h7FFF_FFFF));
    lo = $signed({{(SAT_W-STATE_W){1'b1}}, 32'h8000_0000});
    if (v > hi) begin
      return hi[STATE_W-1:0];
    end else if (v < lo) begin
      return lo[STATE_W-1:0];
    end
    return v[STATE_W-1:0];
  endfunction

  // Unsigned 64-bit quotient by shift and subtract, used only for table constants.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Table entry tanh(step * idx) in Q0.23, t is the step doubled in Q0.31.
  function automatic logic [TANH_W-1:0] tanh_entry(input logic [63:0] t,
                                                   input int unsigned idx);
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    int unsigned n;
    int unsigned j;
    term = 64'd1 << 31;
    r    = 64'd1 << 31;
    e    = 64'd1 << 31;
    for (n = 1; n < 40; n++) begin
      if (term != 64'd0) begin
        term = udiv64((term * t) >> 31, 64'(n));
        if ((n & 1) != 0) begin
          r = r - term;
        end else begin
          r = r + term;
        end
      end
    end
    if (idx == 0) begin
      return '0;
    end
    for (j = 1; j <= idx; j++) begin
      e = (e * r + (64'd1 << 30)) >> 31;
    end
    num = ((64'd1 << 31) - e) << 23;
    den = (64'd1 << 31) + e;
    return TANH_W'(udiv64(num + (den >> 1), den));
  endfunction

endpackage
`default_nettype wire

FILE: src/morphing_state_variable_filter_unit.sv
// One sample at a time: a request is taken only after the last has left ST_RES, where the
// result waits while the output register is full. The sequencer walks one shared 40 x 27
// bit multiplier and one tanh table read port through the whole computation of a sample.
// The output register lets a new sample enter while the last result still waits.
// Reset (rst_n low, synchronous) clears the integrators, the sequencer and the output
// valid flag and restores the register defaults; the tanh table is constant.
`default_nettype none
module morphing_state_variable_filter_unit #(
  parameter int NUM_CHANNELS     = msvf_pkg::NUM_CHANNELS_DEF,
  parameter int TANH_TABLE_DEPTH = msvf_pkg::TANH_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [msvf_pkg::SAMPLE_W-1:0]       in_tdata,   // [23:0] in_sample
  input  wire logic [0:0]                          in_tuser,   // [0] channel
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic      [msvf_pkg::SAMPLE_W-1:0]       out_tdata,  // [23:0] out_sample
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [msvf_pkg::CFG_AW-1:0]         cfg_paddr,
  input  wire logic [msvf_pkg::CFG_DW-1:0]         cfg_pwdata,
  output logic      [msvf_pkg::CFG_DW-1:0]         cfg_prdata,
  output logic                                     cfg_pready
);

  msvf_pkg::cfg_t cfg;
  msvf_pkg::cmd_t cmd;

  msvf_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  msvf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  msvf_dp #(
    .NUM_CHANNELS     (NUM_CHANNELS),
    .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg        (cfg),
    .in_sample  ($signed(in_tdata)),
    .in_channel (in_tuser[0]),
    .out_sample (out_tdata)
  );

endmodule
`default_nettype wire

FILE: src/msvf_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none
module msvf_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [msvf_pkg::CFG_AW-1:0]   cfg_paddr,
  input  wire logic [msvf_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic      [msvf_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                               cfg_pready,
  output msvf_pkg::cfg_t                     cfg
);

  msvf_pkg::cfg_t     cfg_r;
  msvf_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx        = msvf_pkg::reg_idx_t'(cfg_paddr[msvf_pkg::CFG_AW-1:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  // Register writes; unused addresses are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.a1    <= msvf_pkg::A1_RST;
      cfg_r.a2    <= msvf_pkg::A2_RST;
      cfg_r.a3    <= msvf_pkg::A3_RST;
      cfg_r.k     <= msvf_pkg::K_RST;
      cfg_r.morph <= msvf_pkg::MORPH_RST;
      cfg_r.gain  <= msvf_pkg::GAIN_RST;
      cfg_r.pre   <= msvf_pkg::PRE_RST;
    end else if (wr_en) begin
      unique case (idx)
        msvf_pkg::REG_A1:    cfg_r.a1    <= cfg_pwdata[msvf_pkg::COEF_W-1:0];
        msvf_pkg::REG_A2:    cfg_r.a2    <= cfg_pwdata[msvf_pkg::COEF_W-1:0];
        msvf_pkg::REG_A3:    cfg_r.a3    <= cfg_pwdata[msvf_pkg::COEF_W-1:0];
        msvf_pkg::REG_K:     cfg_r.k     <= cfg_pwdata[msvf_pkg::COEF_W-1:0];
        msvf_pkg::REG_MORPH: cfg_r.morph <= cfg_pwdata[msvf_pkg::MORPH_W-1:0];
        msvf_pkg::REG_GAIN:  cfg_r.gain  <= cfg_pwdata[msvf_pkg::GAIN_W-1:0];
        msvf_pkg::REG_PRE:   cfg_r.pre   <= cfg_pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    unique case (idx)
      msvf_pkg::REG_A1:    cfg_prdata = msvf_pkg::CFG_DW'(cfg_r.a1);
      msvf_pkg::REG_A2:    cfg_prdata = msvf_pkg::CFG_DW'(cfg_r.a2);
      msvf_pkg::REG_A3:    cfg_prdata = msvf_pkg::CFG_DW'(cfg_r.a3);
      msvf_pkg::REG_K:     cfg_prdata = msvf_pkg::CFG_DW'(cfg_r.k);
      msvf_pkg::REG_MORPH: cfg_prdata = msvf_pkg::CFG_DW'(cfg_r.morph);
      msvf_pkg::REG_GAIN:  cfg_prdata = msvf_pkg::CFG_DW'(cfg_r.gain);
      msvf_pkg::REG_PRE:   cfg_prdata = msvf_pkg::CFG_DW'(cfg_r.pre);
      default:             cfg_prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/msvf_ctrl.sv
// Sequencer that steps the datapath through one sample and runs both handshakes.
`default_nettype none
module msvf_ctrl (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_tvalid,
  output logic        in_tready,
  output logic        out_tvalid,
  input  wire logic   out_tready,
  output msvf_pkg::cmd_t cmd
);

  msvf_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= msvf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next step and datapath command.
  always_comb begin
    state_nxt    = state_r;
    cmd.op       = state_r;
    cmd.load     = 1'b0;
    cmd.out_load = 1'b0;
    unique case (state_r)
      msvf_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = msvf_pkg::ST_DRV;
        end
      end
      msvf_pkg::ST_DRV:  state_nxt = msvf_pkg::ST_V0;
      msvf_pkg::ST_V0:   state_nxt = msvf_pkg::ST_V3;
      msvf_pkg::ST_V3:   state_nxt = msvf_pkg::ST_A2V3;
      msvf_pkg::ST_A2V3: state_nxt = msvf_pkg::ST_V1;
      msvf_pkg::ST_V1:   state_nxt = msvf_pkg::ST_ACC2;
      msvf_pkg::ST_ACC2: state_nxt = msvf_pkg::ST_V2;
      msvf_pkg::ST_V2:   state_nxt = msvf_pkg::ST_HP;
      msvf_pkg::ST_HP:   state_nxt = msvf_pkg::ST_BL2;
      msvf_pkg::ST_BL2:  state_nxt = msvf_pkg::ST_Y;
      msvf_pkg::ST_Y:    state_nxt = msvf_pkg::ST_YDRV;
      msvf_pkg::ST_YDRV: state_nxt = msvf_pkg::ST_POST;
      msvf_pkg::ST_POST: state_nxt = msvf_pkg::ST_MAG;
      msvf_pkg::ST_MAG:  state_nxt = msvf_pkg::ST_IDX;
      msvf_pkg::ST_IDX:  state_nxt = msvf_pkg::ST_RDLO;
      msvf_pkg::ST_RDLO: state_nxt = msvf_pkg::ST_RDHI;
      msvf_pkg::ST_RDHI: state_nxt = msvf_pkg::ST_INTP;
      msvf_pkg::ST_INTP: state_nxt = msvf_pkg::ST_RES;
      msvf_pkg::ST_RES: begin
        // The result waits here until the output register is free.
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = msvf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = msvf_pkg::ST_IDLE;
    endcase
  end

  // Output register valid flag.
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_tready  = (state_r == msvf_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

FILE: src/msvf_dp.sv
// Datapath: integrator states, one shared multiplier, tanh table and output register.
`default_nettype none
module msvf_dp #(
  parameter int NUM_CHANNELS     = msvf_pkg::NUM_CHANNELS_DEF,
  parameter int TANH_TABLE_DEPTH = msvf_pkg::TANH_DEPTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire msvf_pkg::cmd_t                        cmd,
  input  wire msvf_pkg::cfg_t                        cfg,
  input  wire logic signed [msvf_pkg::SAMPLE_W-1:0]  in_sample,
  input  wire logic                                  in_channel,
  output logic        [msvf_pkg::SAMPLE_W-1:0]       out_sample
);

  localparam int ChW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int IdxW = $clog2(TANH_TABLE_DEPTH + 1);
  localparam logic [63:0] TanhStep = (64'd16 << 31) / TANH_TABLE_DEPTH;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TANH_TABLE_DEPTH);

  localparam int SW = msvf_pkg::STATE_W;
  localparam int VW = msvf_pkg::V_W;
  localparam int YW = msvf_pkg::Y_W;
  localparam int PW = msvf_pkg::PROD_W;
  localparam int AW = msvf_pkg::MA_W;
  localparam int BW = msvf_pkg::MB_W;
  localparam int FW = msvf_pkg::FRAC_W;
  localparam int TW = msvf_pkg::TANH_W;

  // Integrator pair per channel.
  logic signed [SW-1:0] ic1_r [NUM_CHANNELS];
  logic signed [SW-1:0] ic2_r [NUM_CHANNELS];

  logic signed [msvf_pkg::SAMPLE_W-1:0] x_r;
  logic        [ChW-1:0]                ch_r;
  logic signed [SW-1:0]                 ic1_v_r, ic2_v_r;
  logic signed [msvf_pkg::V0_W-1:0]     v0_r;
  logic signed [VW-1:0]                 v3_r, v1_r, v2_r, hp_r;
  logic signed [YW-1:0]                 y_r;
  logic signed [PW-1:0]                 acc_r, prod_r;
  logic                                 neg_r, big_r, last_r;
  logic        [IdxW-1:0]               idx_r;
  logic        [FW-1:0]                 frac_r;
  logic        [TW-1:0]                 lo_r, rom_q_r;
  logic        [msvf_pkg::SAMPLE_W-1:0] out_sample_r;

  logic [ChW-1:0]               ch_sel;
  logic signed [PW-1:0]         sum_c;
  logic [msvf_pkg::MORPH_W-1:0] m_c, b_c, w_c;
  logic [msvf_pkg::MORPH_W:0]   dbl_c, b18_c;
  logic                         m_low;
  logic [YW-1:0]                y_mag;
  logic [TW-1:0]                d_c;
  logic signed [AW-1:0]         ma;
  logic signed [BW-1:0]         mb;
  logic signed [AW+BW-1:0]      mul_full;
  logic [IdxW-1:0]              rom_addr;
  logic [IdxW-1:0]              idx_c;
  logic [24:0]                  res_sum, res_raw;
  logic [TW-1:0]                res_cl;
  logic signed [SW-1:0]         ic1_new, ic2_new;

  // Constant tanh table, read through a registered port.
  logic [TW-1:0] tanh_rom [TANH_TABLE_DEPTH+1];
  for (genvar gi = 0; gi <= TANH_TABLE_DEPTH; gi++) begin : g_rom
    localparam logic [TW-1:0] Entry = msvf_pkg::tanh_entry(TanhStep, gi);
    assign tanh_rom[gi] = Entry;
  end

  assign ch_sel = (NUM_CHANNELS > 1) ? ChW'(in_channel) : '0;
  assign sum_c  = acc_r + prod_r;

  // Morph blend weights: b and 1 - b in Q0.16.
  always_comb begin
    m_c   = (cfg.morph > msvf_pkg::MORPH_ONE) ? msvf_pkg::MORPH_ONE : cfg.morph;
    m_low = (m_c < msvf_pkg::MORPH_HALF);
    dbl_c = {m_c, 1'b0};
    b18_c = m_low ? dbl_c : dbl_c - {1'b0, msvf_pkg::MORPH_ONE};
    b_c   = b18_c[msvf_pkg::MORPH_W-1:0];
    w_c   = msvf_pkg::MORPH_ONE - b_c;
  end

  assign y_mag = y_r[YW-1] ? YW'(-y_r) : YW'(y_r);
  assign d_c   = (rom_q_r >= lo_r) ? rom_q_r - lo_r : '0;
  assign idx_c = prod_r[FW +: IdxW];

  // Shared multiplier operand selection.
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      msvf_pkg::ST_DRV: begin
        ma = AW'(x_r);
        mb = $signed(BW'(cfg.gain));
      end
      msvf_pkg::ST_V0: begin
        ma = AW'(ic1_v_r);
        mb = $signed(BW'(cfg.a1));
      end
      msvf_pkg::ST_A2V3: begin
        ma = v3_r;
        mb = $signed(BW'(cfg.a2));
      end
      msvf_pkg::ST_V1: begin
        ma = AW'(ic1_v_r);
        mb = $signed(BW'(cfg.a2));
      end
      msvf_pkg::ST_ACC2: begin
        ma = v3_r;
        mb = $signed(BW'(cfg.a3));
      end
      msvf_pkg::ST_V2: begin
        ma = v1_r;
        mb = $signed(BW'(cfg.k));
      end
      msvf_pkg::ST_HP: begin
        ma = m_low ? v2_r : v1_r;
        mb = $signed(BW'(w_c));
      end
      msvf_pkg::ST_BL2: begin
        ma = m_low ? v1_r : hp_r;
        mb = $signed(BW'(b_c));
      end
      msvf_pkg::ST_YDRV: begin
        ma = AW'(y_r);
        mb = $signed(BW'(cfg.gain));
      end
      msvf_pkg::ST_MAG: begin
        ma = $signed(AW'(y_mag[FW-1:0]));
        mb = $signed(BW'(TANH_TABLE_DEPTH));
      end
      msvf_pkg::ST_INTP, msvf_pkg::ST_RES: begin
        ma = $signed(AW'(d_c));
        mb = $signed(BW'(frac_r));
      end
      default: begin
      end
    endcase
  end

  assign mul_full = ma * mb;

  // Table address: low neighbor, then high neighbor, held while the result waits.
  always_comb begin
    if (last_r) begin
      rom_addr = LastIdx;
    end else if (cmd.op == msvf_pkg::ST_RDHI || cmd.op == msvf_pkg::ST_INTP
                 || cmd.op == msvf_pkg::ST_RES) begin
      rom_addr = idx_r + IdxW'(1);
    end else begin
      rom_addr = idx_r;
    end
  end

  // Integrator updates.
  assign ic1_new = msvf_pkg::sat32((msvf_pkg::SAT_W'(v1_r) <<< 1)
                                   - msvf_pkg::SAT_W'(ic1_v_r));
  assign ic2_new = msvf_pkg::sat32((msvf_pkg::SAT_W'(v2_r) <<< 1)
                                   - msvf_pkg::SAT_W'(ic2_v_r));

  // Soft-clip interpolation and full-scale clamp.
  always_comb begin
    res_sum = 25'(lo_r) + 25'(msvf_pkg::rnd_sh(prod_r, FW));
    res_raw = last_r ? 25'(lo_r) : res_sum;
    res_cl  = (res_raw > msvf_pkg::OUT_MAX) ? TW'(msvf_pkg::OUT_MAX) : res_raw[TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        ic1_r[i] <= '0;
        ic2_r[i] <= '0;
      end
    end else if (cmd.op == msvf_pkg::ST_HP) begin
      ic1_r[ch_r] <= ic1_new;
      ic2_r[ch_r] <= ic2_new;
    end
  end

  // Datapath registers, one step per cycle; the step holds in ST_RES while a result waits.
  always_ff @(posedge clk) begin
    prod_r  <= mul_full[PW-1:0];
    rom_q_r <= tanh_rom[rom_addr];
    if (cmd.load) begin
      x_r     <= in_sample;
      ch_r    <= ch_sel;
      ic1_v_r <= ic1_r[ch_sel];
      ic2_v_r <= ic2_r[ch_sel];
    end
    if (cmd.out_load) begin
      out_sample_r <= neg_r ? TW'(-res_cl) : res_cl;
    end
    unique case (cmd.op)
      msvf_pkg::ST_V0: begin
        v0_r <= cfg.pre ? msvf_pkg::V0_W'(msvf_pkg::rnd_sh(prod_r, 12))
                        : msvf_pkg::V0_W'(x_r);
      end
      msvf_pkg::ST_V3: begin
        acc_r <= prod_r;
        v3_r  <= VW'(v0_r) - VW'(ic2_v_r);
      end
      msvf_pkg::ST_V1:   v1_r  <= VW'(msvf_pkg::rnd_sh(sum_c, 17));
      msvf_pkg::ST_ACC2: acc_r <= prod_r;
      msvf_pkg::ST_V2:   v2_r  <= VW'(ic2_v_r) + VW'(msvf_pkg::rnd_sh(sum_c, 17));
      msvf_pkg::ST_HP: begin
        hp_r <= VW'(v0_r) - VW'(msvf_pkg::rnd_sh(prod_r, 16)) - v2_r;
      end
      msvf_pkg::ST_BL2:  acc_r <= prod_r;
      msvf_pkg::ST_Y:    y_r   <= YW'(msvf_pkg::rnd_sh(sum_c, 16));
      msvf_pkg::ST_POST: begin
        if (!cfg.pre) begin
          y_r <= YW'(msvf_pkg::rnd_sh(prod_r, 12));
        end
      end
      msvf_pkg::ST_MAG: begin
        neg_r <= y_r[YW-1];
        big_r <= (y_mag[YW-1:FW] != '0);
      end
      msvf_pkg::ST_IDX: begin
        idx_r  <= idx_c;
        frac_r <= prod_r[FW-1:0];
        last_r <= big_r || (idx_c >= LastIdx);
      end
      msvf_pkg::ST_RDHI: lo_r <= rom_q_r;
      default: begin
      end
    endcase
  end

  assign out_sample = out_sample_r;

endmodule
`default_nettype wire

FILE: src/msvf_checker.sv
// Port-level checker for the filter unit and its bind to the top level.
`default_nettype none
module msvf_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [msvf_pkg::SAMPLE_W-1:0]   out_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // One sample at a time: no new request right after one is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a sample is in work");

  // A fresh result never appears in the cycle after a request is taken.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared too early");

  // A result only appears at the end of work, while input was closed.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared while idle");

endmodule

bind morphing_state_variable_filter_unit msvf_checker u_msvf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for the morphing state-variable filter unit.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

  localparam int TABLE_DEPTH = 256;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [msvf_pkg::SAMPLE_W-1:0] in_tdata;   // [23:0] in_sample
  logic [0:0] in_tuser;                      // [0] channel
  logic out_tvalid;
  logic out_tready;
  logic [msvf_pkg::SAMPLE_W-1:0] out_tdata;  // [23:0] out_sample
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [msvf_pkg::CFG_AW-1:0] cfg_paddr;
  logic [msvf_pkg::CFG_DW-1:0] cfg_pwdata;
  logic [msvf_pkg::CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  morphing_state_variable_filter_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Predicts filter output samples and checks the ones the block returns.
  class filter_scoreboard;
    logic [msvf_pkg::COEF_W-1:0] a1, a2, a3, damp;
    logic [msvf_pkg::MORPH_W-1:0] morph_pos;
    logic [msvf_pkg::GAIN_W-1:0] gain;
    logic pre_drive;
    longint integ [4];
    longint tanh_lut [TABLE_DEPTH+1];
    logic [msvf_pkg::SAMPLE_W-1:0] expected_samples [$];
    int mismatches;
    int checked;

    function new();
      longint unsigned t, term, e, num, den;
      longint r;
      a1 = msvf_pkg::A1_RST; a2 = msvf_pkg::A2_RST; a3 = msvf_pkg::A3_RST;
      damp = msvf_pkg::K_RST;
      morph_pos = msvf_pkg::MORPH_RST; gain = msvf_pkg::GAIN_RST;
      pre_drive = msvf_pkg::PRE_RST;
      foreach (integ[i]) integ[i] = 0;
      mismatches = 0;
      checked = 0;
      // Build the tanh table from a series for e^(-16/D).
      t = (64'd16 << 31) / TABLE_DEPTH;
      term = 64'd1 << 31;
      r = 64'sd1 << 31;
      e = 64'd1 << 31;
      for (int n = 1; n < 40 && term != 0; n++) begin
        term = ((term * t) >> 31) / n;
        if (n % 2 == 1) r -= longint'(term); else r += longint'(term);
      end
      tanh_lut[0] = 0;
      for (int i = 1; i <= TABLE_DEPTH; i++) begin
        e = (e * longint'(r) + (64'd1 << 30)) >> 31;
        num = ((64'd1 << 31) - e) << 23;
        den = (64'd1 << 31) + e;
        tanh_lut[i] = longint'((num + den / 2) / den);
      end
    endfunction

    function longint round_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void write_reg(msvf_pkg::reg_idx_t idx, logic [msvf_pkg::CFG_DW-1:0] value);
      case (idx)
        msvf_pkg::REG_A1: a1 = value[msvf_pkg::COEF_W-1:0];
        msvf_pkg::REG_A2: a2 = value[msvf_pkg::COEF_W-1:0];
        msvf_pkg::REG_A3: a3 = value[msvf_pkg::COEF_W-1:0];
        msvf_pkg::REG_K: damp = value[msvf_pkg::COEF_W-1:0];
        msvf_pkg::REG_MORPH: morph_pos = value[msvf_pkg::MORPH_W-1:0];
        msvf_pkg::REG_GAIN: gain = value[msvf_pkg::GAIN_W-1:0];
        msvf_pkg::REG_PRE: pre_drive = value[0];
        default: ;
      endcase
    endfunction

    // Runs one sample through the filter model and queues the result.
    function void note_sample(logic [msvf_pkg::SAMPLE_W-1:0] sample, logic chan);
      longint x, ic1, ic2, v0, v1, v2, v3, hp, y, m, b, mag, res, pos, idx, frac, lo, hi, d;
      x = longint'($signed(sample));
      ic1 = integ[2 * chan];
      ic2 = integ[2 * chan + 1];
      v0 = pre_drive ? round_shift(x * longint'(gain), 12) : x;
      v3 = v0 - ic2;
      v1 = round_shift(longint'(a1) * ic1 + longint'(a2) * v3, 17);
      v2 = ic2 + round_shift(longint'(a2) * ic1 + longint'(a3) * v3, 17);
      hp = v0 - round_shift(longint'(damp) * v1, 16) - v2;
      integ[2 * chan] = clamp32(2 * v1 - ic1);
      integ[2 * chan + 1] = clamp32(2 * v2 - ic2);
      m = (morph_pos > msvf_pkg::MORPH_ONE) ? 65536 : longint'(morph_pos);
      if (m < 32768) begin
        b = 2 * m;
        y = round_shift(v2 * (65536 - b) + v1 * b, 16);
      end else begin
        b = 2 * m - 65536;
        y = round_shift(v1 * (65536 - b) + hp * b, 16);
      end
      if (!pre_drive) y = round_shift(y * longint'(gain), 12);
      // Soft clip through the interpolated tanh table.
      mag = (y < 0) ? -y : y;
      if (mag >= (64'sd1 << msvf_pkg::FRAC_W)) begin
        res = tanh_lut[TABLE_DEPTH];
      end else begin
        pos = mag * TABLE_DEPTH;
        idx = pos >>> msvf_pkg::FRAC_W;
        frac = pos & ((64'sd1 << msvf_pkg::FRAC_W) - 1);
        lo = tanh_lut[idx];
        hi = tanh_lut[idx + 1];
        d = (hi >= lo) ? hi - lo : 0;
        res = lo + ((d * frac + (64'sd1 << (msvf_pkg::FRAC_W - 1))) >>> msvf_pkg::FRAC_W);
      end
      if (res > 8388607) res = 8388607;
      if (y < 0) res = -res;
      expected_samples.push_back(res[msvf_pkg::SAMPLE_W-1:0]);
    endfunction

    function void check_sample(logic [msvf_pkg::SAMPLE_W-1:0] got);
      logic [msvf_pkg::SAMPLE_W-1:0] want;
      checked++;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected output sample %0d", $signed(got));
        return;
      end
      want = expected_samples.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("out_sample mismatch: expected %0d, got %0d", $signed(want), $signed(got));
      end
    endfunction
  endclass

  filter_scoreboard board;
  int send_idle_pct;
  int recv_idle_pct;
  longint cycle_count;
  int samples_sent;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cycle limit guards against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random stalls and checking of every result taken.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) board.check_sample(out_tdata);
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // One register write: setup cycle, access cycle, then the bus idles.
  task automatic write_cfg(msvf_pkg::reg_idx_t idx, logic [msvf_pkg::CFG_DW-1:0] value);
    in_tvalid <= 1'b0;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= msvf_pkg::CFG_AW'(4 * int'(idx));
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    board.write_reg(idx, value);
    @(posedge clk);
  endtask

  // Offers one request; the valid flag stays up for a following request without idling.
  task automatic send_sample(logic [msvf_pkg::SAMPLE_W-1:0] sample, logic chan);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= sample;
    in_tuser <= chan;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_sample(sample, chan);
    samples_sent++;
  endtask

  // Waits until every expected sample has returned, then idles before returning.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.expected_samples.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic random_settings();
    write_cfg(msvf_pkg::REG_A1, $urandom_range(131072));
    write_cfg(msvf_pkg::REG_A2, $urandom_range(131072));
    write_cfg(msvf_pkg::REG_A3, $urandom_range(131072));
    write_cfg(msvf_pkg::REG_K, $urandom_range(131072));
    write_cfg(msvf_pkg::REG_MORPH, ($urandom_range(9) == 0) ? $urandom_range(131071)
                                                             : $urandom_range(65536));
    write_cfg(msvf_pkg::REG_GAIN, ($urandom_range(3) == 0) ? $urandom_range(65535)
                                                            : $urandom_range(8192));
    write_cfg(msvf_pkg::REG_PRE, $urandom_range(1));
  endtask

  task automatic random_samples(int count);
    logic [msvf_pkg::SAMPLE_W-1:0] s;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: s = msvf_pkg::SAMPLE_W'($urandom);
        1: s = msvf_pkg::SAMPLE_W'($signed($urandom_range(2000)) - 1000);
        2: s = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
        default: s = msvf_pkg::SAMPLE_W'($signed($urandom_range(400000)) - 200000);
      endcase
      send_sample(s, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    board = new();
    cycle_count = 0;
    samples_sent = 0;
    send_idle_pct = 38;
    recv_idle_pct = 46;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: default settings, extreme samples on both channels.
    send_sample(24'h7FFFFF, 1'b0);
    send_sample(24'h800000, 1'b1);
    send_sample(24'h000000, 1'b0);
    send_sample(24'hFFFFFF, 1'b1);
    send_sample(24'h555555, 1'b0);
    send_sample(24'hAAAAAA, 1'b1);
    // Sender holds off until the pipeline is empty.
    drain();
    // Directed: a1 to a3 at 131072, no damping and maximum gain to push integrators into saturation.
    write_cfg(msvf_pkg::REG_A1, 131072);
    write_cfg(msvf_pkg::REG_A2, 131072);
    write_cfg(msvf_pkg::REG_A3, 131072);
    write_cfg(msvf_pkg::REG_K, 0);
    write_cfg(msvf_pkg::REG_MORPH, 65536);
    write_cfg(msvf_pkg::REG_GAIN, 65535);
    write_cfg(msvf_pkg::REG_PRE, 1);
    for (int i = 0; i < 6; i++) send_sample((i % 2) ? 24'h800000 : 24'h7FFFFF, i[1]);
    drain();
    // Directed: morph above one, drive after the filter, zero a1.
    write_cfg(msvf_pkg::REG_MORPH, 131071);
    write_cfg(msvf_pkg::REG_PRE, 0);
    write_cfg(msvf_pkg::REG_A1, 0);
    write_cfg(msvf_pkg::REG_K, 131072);
    send_sample(24'h400000, 1'b0);
    send_sample(24'hC00000, 1'b1);
    drain();
    write_cfg(msvf_pkg::REG_MORPH, 32768);
    send_sample(24'h123456, 1'b0);
    drain();
    write_cfg(msvf_pkg::REG_MORPH, 32767);
    send_sample(24'hFEDCBA, 1'b1);
    drain();

    // Random phases under the three idling patterns.
    for (int phase = 0; phase < 21; phase++) begin
      if (phase == 7) begin
        send_idle_pct = 46;
        recv_idle_pct = 38;
      end else if (phase == 14) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_settings();
      random_samples(82);
      drain();
    end

    $display("Covered %0d samples over directed extremes and 21 random register settings.",
             samples_sent);
    $display("Checked %0d results, %0d mismatches.", board.checked, board.mismatches);
    if (board.mismatches == 0 && board.expected_samples.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
